>>> hdl/md5sb_pkg.sv
// Shared types, constants and round functions of the single-block MD5 digest.
`timescale 1ns / 1ps

package md5sb_pkg;

   localparam int COUNT_W = 6;
   localparam int ROUND_W = 6;
   localparam int WORDS   = 16;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef logic [WORDS-1:0][31:0] block_type;

   typedef struct packed {
      logic      too_long;
      block_type words;
   } entry_type;

   function automatic logic [31:0] sine_value(input logic [ROUND_W-1:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word used by each round, modulo 16.
   function automatic logic [3:0] msg_index(input logic [ROUND_W-1:0] idx);
      logic [3:0] i;
      logic [3:0] g;
      i = idx[3:0];
      case (idx[5:4])
         2'd0:    g = i;
         2'd1:    g = (i << 2) + i + 4'd1;
         2'd2:    g = (i << 1) + i + 4'd5;
         default: g = (i << 3) - i;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

>>> hdl/md5sb_front.sv
// Front end: packs message bytes, pads the block and hands it to the queue.
`timescale 1ns / 1ps

module md5sb_front #(
   parameter int MAX_MESSAGE_BYTES = 55
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_byte_valid,
   input  logic                 req_last_byte,
   input  logic                 queue_full,
   output logic                 push,
   output md5sb_pkg::entry_type push_entry
);

   localparam logic [md5sb_pkg::COUNT_W-1:0] MAX_COUNT =
      md5sb_pkg::COUNT_W'(MAX_MESSAGE_BYTES);

   logic [md5sb_pkg::COUNT_W-1:0] count_ff, count_in, count_upd;
   logic                          overflow_ff, overflow_in, overflow_upd;
   md5sb_pkg::block_type          words_ff, words_in, words_upd, words_pad;
   logic                          accept, store;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign store     = req_byte_valid && (count_ff < MAX_COUNT);
   assign push      = accept && req_last_byte;

   always_comb begin
      words_upd    = words_ff;
      count_upd    = count_ff;
      overflow_upd = overflow_ff | (req_byte_valid & ~store);
      if (store) begin
         words_upd[count_ff[5:2]][{count_ff[1:0], 3'b000} +: 8] = req_data_byte;
         count_upd = count_ff + 1'b1;
      end
      // Pad byte after the message, bit length in word 14, word 15 zero.
      words_pad = words_upd;
      words_pad[count_upd[5:2]][{count_upd[1:0], 3'b000} +: 8] = md5sb_pkg::PAD_BYTE;
      words_pad[14] = {23'd0, count_upd, 3'b000};
      words_pad[15] = 32'd0;
      push_entry.too_long = overflow_upd;
      push_entry.words    = words_pad;

      words_in    = words_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (push) begin
         words_in    = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (accept) begin
         words_in    = words_upd;
         count_in    = count_upd;
         overflow_in = overflow_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff    <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         words_ff    <= words_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

>>> hdl/md5sb_queue.sv
// Two-entry queue of padded blocks between the front and back ends.
`timescale 1ns / 1ps

module md5sb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  md5sb_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output md5sb_pkg::entry_type head
);

   md5sb_pkg::entry_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> hdl/md5sb_back.sv
// Back end: runs the 64 MD5 rounds on the queue head (or skips them for a flagged block) and registers the result.
`timescale 1ns / 1ps

module md5sb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  md5sb_pkg::entry_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_digest_high,
   output logic [63:0]          rsp_digest_low,
   output logic                 rsp_too_long
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINISH} state_type;

   state_type                     state_ff, state_in;
   logic [md5sb_pkg::ROUND_W-1:0] round_ff, round_in;
   logic [31:0]                   a_ff, b_ff, c_ff, d_ff;
   logic [31:0]                   a_in, b_in, c_in, d_in;
   logic                          valid_ff, valid_in;
   logic [63:0]                   high_ff, high_in, low_ff, low_in;
   logic                          long_ff, long_in;
   logic                          out_free;
   logic [31:0]                   f, sum, new_b;

   assign out_free        = !valid_ff || !rsp_stall;
   assign rsp_valid       = valid_ff;
   assign rsp_digest_high = high_ff;
   assign rsp_digest_low  = low_ff;
   assign rsp_too_long    = long_ff;

   // One round per cycle.
   always_comb begin
      case (round_ff[5:4])
         2'd0:    f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum   = a_ff + f + md5sb_pkg::sine_value(round_ff)
              + head.words[md5sb_pkg::msg_index(round_ff)];
      new_b = b_ff + md5sb_pkg::rotl32(sum, md5sb_pkg::rot_amount(round_ff));
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      valid_in = valid_ff && rsp_stall;
      high_in  = high_ff;
      low_in   = low_ff;
      long_in  = long_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head.too_long) begin
                  // Flagged message: skip the rounds, emit zeros.
                  if (out_free) begin
                     valid_in = 1'b1;
                     high_in  = '0;
                     low_in   = '0;
                     long_in  = 1'b1;
                     pop      = 1'b1;
                  end
               end else begin
                  a_in     = md5sb_pkg::IV_A;
                  b_in     = md5sb_pkg::IV_B;
                  c_in     = md5sb_pkg::IV_C;
                  d_in     = md5sb_pkg::IV_D;
                  round_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = new_b;
            round_in = round_ff + 1'b1;
            if (round_ff == '1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               valid_in = 1'b1;
               high_in  = {md5sb_pkg::swap32(a_ff + md5sb_pkg::IV_A),
                           md5sb_pkg::swap32(b_ff + md5sb_pkg::IV_B)};
               low_in   = {md5sb_pkg::swap32(c_ff + md5sb_pkg::IV_C),
                           md5sb_pkg::swap32(d_ff + md5sb_pkg::IV_D)};
               long_in  = 1'b0;
               pop      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      high_ff <= high_in;
      low_ff  <= low_in;
      long_ff <= long_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> hdl/md5_single_block_digest.sv
// Top level of the single-block MD5 digest engine.
`timescale 1ns / 1ps

// Computes the MD5 digest of a message of up to MAX_MESSAGE_BYTES bytes that
// fits in one 512-bit block. Send one byte per transfer on the req_ channel
// with req_byte_valid set; mark the final transfer with req_last_byte (a
// transfer with req_last_byte alone ends the message without a byte, which
// also yields the digest of the empty message). Every message end produces
// exactly one rsp_ transfer: the 128-bit digest in standard byte order, byte
// 0 in bits 63:56 of rsp_digest_high, or rsp_too_long with zero digest
// fields when more bytes arrived than the limit (the extra bytes are
// dropped). Rate: the front end takes one byte per cycle unless stalled and
// pads the block in the cycle of the last byte; the compression unit runs
// one round per cycle, and in the back end a message passes a load step,
// the 64 rounds and a finalize step, so throughput is set by the single
// shared round unit. A two-block queue between the parts lets the
// next message load while the current one compresses; the front end stalls
// only while both queue slots are occupied. A flagged message skips the
// rounds and is emitted straight from the idle state.
module md5_single_block_digest #(
   parameter int MAX_MESSAGE_BYTES = 55
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_high,
   output logic [63:0] rsp_digest_low,
   output logic        rsp_too_long
);

   logic                 push, pop, queue_full, head_valid;
   md5sb_pkg::entry_type push_entry, head;

   // Pack and classify bytes; push a finished block at each message end.
   md5sb_front #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_last_byte  (req_last_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Hold finished blocks until the compression unit takes them.
   md5sb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Compress the head block and drive the result register.
   md5sb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_high (rsp_digest_high),
      .rsp_digest_low  (rsp_digest_low),
      .rsp_too_long    (rsp_too_long)
   );

endmodule

>>> sim/md5_single_block_digest_tb.sv
// Self-checking testbench for the single-block MD5 digest engine.
`timescale 1ns / 1ps

module md5_single_block_digest_tb;

   // Byte limit of one message; bytes beyond it are dropped and flagged.
   localparam int MSG_LIMIT = 55;
   // Abort the run at this cycle count.
   localparam int CYCLE_LIMIT = 600000;
   // Cycles to keep watching after the last digest, covering one full compression.
   localparam int TAIL_CYCLES = 150;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate amounts, by round group and by round number modulo 4.
   localparam int ROT_BY [4][4] = '{
      '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
   };

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
      logic        too_long;
   } digest_type;

   // Clock, reset and DUT ports; every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_high;
   logic [63:0] rsp_digest_low;
   logic        rsp_too_long;

   // Predictor state: the message block being assembled.
   logic [31:0] msg_block [16];
   int unsigned msg_len = 0;
   bit          msg_overflow = 1'b0;

   digest_type  pending_digests [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sent_items = 0;
   int unsigned sent_messages = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;

   md5_single_block_digest #(
      .MAX_MESSAGE_BYTES(MSG_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_high (rsp_digest_high),
      .rsp_digest_low  (rsp_digest_low),
      .rsp_too_long    (rsp_too_long)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [31:0] byte_reverse(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   // Pad the assembled block and run the 64 rounds from the initial chain.
   function automatic digest_type compute_digest();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int unsigned g;
      int unsigned s;
      digest_type  result;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      w[msg_len / 4] = w[msg_len / 4] | (32'h80 << (8 * (msg_len % 4)));
      w[14] = 32'(msg_len * 8);
      w[15] = 32'h0;
      a = INIT_A;
      b = INIT_B;
      c = INIT_C;
      d = INIT_D;
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t = a + f + ROUND_K[r] + w[g];
         s = ROT_BY[r / 16][r % 4];
         t = b + ((t << s) | (t >> (32 - s)));
         a = d;
         d = c;
         c = b;
         b = t;
      end
      result.high     = {byte_reverse(a + INIT_A), byte_reverse(b + INIT_B)};
      result.low      = {byte_reverse(c + INIT_C), byte_reverse(d + INIT_D)};
      result.too_long = 1'b0;
      return result;
   endfunction

   task automatic clear_message();
      for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
      msg_len = 0;
      msg_overflow = 1'b0;
   endtask

   // Fold one accepted transfer into the message; queue a digest on its end.
   task automatic take_message_item(input logic [7:0] data, input logic has_byte,
                                    input logic ends_msg);
      digest_type want;
      if (has_byte) begin
         if (msg_len < MSG_LIMIT) begin
            msg_block[msg_len / 4] = msg_block[msg_len / 4] |
                                     ({24'h0, data} << (8 * (msg_len % 4)));
            msg_len++;
         end else begin
            // Drop the byte; the whole message is now flagged.
            msg_overflow = 1'b1;
         end
      end
      if (ends_msg) begin
         if (msg_overflow) begin
            want = '{high: 64'h0, low: 64'h0, too_long: 1'b1};
         end else begin
            want = compute_digest();
         end
         pending_digests.push_back(want);
         clear_message();
      end
   endtask

   // ---------------------------------------------------------------------
   // Checker: predict on each input transfer, compare each output transfer.
   // Both happen in one process so a same-edge push and pop cannot race.
   // ---------------------------------------------------------------------

   task automatic check_digest();
      digest_type want;
      if (pending_digests.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected digest: high=%h low=%h too_long=%b",
                     rsp_digest_high, rsp_digest_low, rsp_too_long);
      end else begin
         want = pending_digests.pop_front();
         if (rsp_digest_high !== want.high || rsp_digest_low !== want.low ||
             rsp_too_long !== want.too_long) begin
            error_count++;
            if (error_count <= 10)
               $display({"digest mismatch: expected high=%h low=%h too_long=%b,",
                         " got high=%h low=%h too_long=%b"},
                        want.high, want.low, want.too_long,
                        rsp_digest_high, rsp_digest_low, rsp_too_long);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            take_message_item(req_data_byte, req_byte_valid, req_last_byte);
         if (rsp_valid && !rsp_stall)
            check_digest();
      end
   end

   // Stall the result channel at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Present one item and hold it until the transfer. Valid is left high on
   // return so back-to-back items never drop it; a gap lowers it first.
   task automatic send_item(input logic [7:0] data, input logic has_byte,
                            input logic ends_msg);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_byte_valid <= has_byte;
      req_last_byte  <= ends_msg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send a message of random bytes. When split_end is set, or the message is
   // empty, the end comes as a separate transfer with no byte; its data is noise.
   // Ignored transfers with neither flag are sprinkled in between.
   task automatic send_message(input int unsigned len, input bit split_end,
                               input int unsigned noise_pct);
      bit ends_here;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         ends_here = (i == len - 1) && !split_end;
         send_item(8'($urandom_range(255)), 1'b1, ends_here);
         sent_items++;
      end
      if (split_end || len == 0) begin
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
         sent_items++;
      end
      sent_messages++;
   endtask

   // Send a fixed byte string, ending on its last byte.
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_item(text[i], 1'b1, i == text.len() - 1);
         sent_items++;
      end
      sent_messages++;
   endtask

   // Empty message: end flag alone, its data byte ignored.
   task automatic test_empty_message();
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      sent_items += 2;
      sent_messages += 2;
   endtask

   // Short text messages, ending on a byte and ending on a byte-less transfer.
   task automatic test_short_text();
      send_text("abc");
      send_item("a", 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      sent_items += 2;
      sent_messages++;
   endtask

   // Transfers with neither flag must leave the message untouched.
   task automatic test_ignored_items();
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'haa, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h55, 1'b0, 1'b0);
      sent_items += 2;
      sent_messages++;
   endtask

   // Length extremes: exactly at the limit, one byte under and one byte over,
   // and well over, the under and well-over cases ending on a byte-less transfer.
   task automatic test_length_limit();
      send_message(MSG_LIMIT, 1'b0, 0);
      send_message(MSG_LIMIT - 1, 1'b1, 0);
      send_message(MSG_LIMIT + 1, 1'b0, 0);
      send_message(MSG_LIMIT + 4, 1'b1, 0);
   endtask

   // Random messages, weighted toward short ones so digests come often.
   task automatic test_random_messages(input int unsigned item_goal,
                                       input int unsigned msg_goal);
      int unsigned item_base;
      int unsigned msg_base;
      int unsigned pick;
      int unsigned len;
      item_base = sent_items;
      msg_base  = sent_messages;
      while (sent_items - item_base < item_goal || sent_messages - msg_base < msg_goal) begin
         pick = $urandom_range(99);
         if (pick < 40)
            len = $urandom_range(8, 0);
         else if (pick < 75)
            len = $urandom_range(MSG_LIMIT - 1, 9);
         else if (pick < 85)
            len = MSG_LIMIT;
         else
            len = $urandom_range(MSG_LIMIT + 8, MSG_LIMIT + 1);
         send_message(len, $urandom_range(2) == 0, 5);
      end
   endtask

   initial begin
      clear_message();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sender idles often, receiver stalls more often.
      send_gap_pct   = 32;
      recv_stall_pct = 45;
      test_empty_message();
      test_short_text();
      test_ignored_items();
      test_length_limit();
      test_random_messages(140, 4);

      // Swap the pressure.
      send_gap_pct   = 45;
      recv_stall_pct = 32;
      test_random_messages(140, 4);

      // Full rate on both sides.
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      test_random_messages(140, 4);

      // Drop valid, drain outstanding digests, then watch for strays.
      req_valid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
